[design/assert_macros.svh]
// Assertion helpers used by the RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/iirdec_pkg.sv]
package iirdec_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int COEF_W       = 20;
    localparam int PROD_W       = SAMPLE_W + COEF_W;
    localparam int ACC_W        = 64;
    localparam int COEF_IDX_W   = 10;
    localparam int TAPS_DEFAULT = 136;
    // Reciprocal divide stages: multiply, sum, multiply back, correct.
    localparam int DIV_STEPS    = 4;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // write new sample, clear accumulator, rewind tap walk
        logic issue;     // read one tap from both histories
        logic div_init;  // take accumulator magnitude, check overflow
        logic div_step;  // advance the reciprocal divide by one stage
        logic finish;    // store and register the result, advance ring
    } idc_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic last_tap;
        logic pipe_busy;
    } idc_stat_t;

    // Feedforward coefficients, truncated toward zero.
    function automatic logic signed [COEF_W-1:0] ff_coef(input logic [COEF_IDX_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        unique case (idx)
            10'd0:   c = 20'sd372;
            10'd1:   c = -20'sd63;
            10'd2:   c = -20'sd198;
            10'd3:   c = -20'sd65;
            10'd4:   c = -20'sd7;
            10'd125: c = 20'sd2097;
            10'd126: c = 20'sd1595;
            10'd127: c = -20'sd3559;
            10'd128: c = -20'sd2849;
            10'd129: c = 20'sd1141;
            10'd130: c = 20'sd1230;
            10'd131: c = 20'sd331;
            10'd132: c = 20'sd33;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Feedback coefficients, truncated toward zero; entry 0 is the divisor.
    function automatic logic signed [COEF_W-1:0] fb_coef(input logic [COEF_IDX_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        unique case (idx)
            10'd0:   c = 20'sd372107;
            10'd1:   c = -20'sd63816;
            10'd2:   c = -20'sd198153;
            10'd3:   c = -20'sd65034;
            10'd4:   c = -20'sd7169;
            10'd5:   c = -20'sd99;
            10'd6:   c = 20'sd15;
            10'd127: c = -20'sd93026;
            10'd128: c = -20'sd170099;
            10'd129: c = -20'sd11580;
            10'd130: c = 20'sd131289;
            10'd131: c = 20'sd83848;
            10'd132: c = 20'sd19868;
            10'd133: c = 20'sd1838;
            10'd134: c = 20'sd17;
            10'd135: c = -20'sd3;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

[design/iirdec_dp.sv]
module iirdec_dp #(
    parameter int TAPS = iirdec_pkg::TAPS_DEFAULT
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  iirdec_pkg::idc_cmd_t                     cmd,
    output iirdec_pkg::idc_stat_t                    stat,
    input  logic signed [iirdec_pkg::SAMPLE_W-1:0]   sample_in,
    output logic signed [iirdec_pkg::SAMPLE_W-1:0]   sample_out
);
    import iirdec_pkg::*;

    localparam int PW = $clog2(TAPS);
    localparam int FW = $clog2(TAPS + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(TAPS - 1);
    localparam logic [FW-1:0] FULL_CNT = FW'(TAPS);
    localparam logic signed [COEF_W-1:0] DIVISOR = fb_coef('0);
    localparam logic [COEF_W-1:0] DIV_MAG =
        DIVISOR[COEF_W-1] ? COEF_W'(-DIVISOR) : COEF_W'(DIVISOR);

    // Reciprocal of the divisor magnitude. A quotient that fits 32 bits comes
    // from a dividend below 2^RCP_SHIFT, so the estimate is low by at most one.
    localparam int MAG_W     = SAMPLE_W + COEF_W;
    localparam int LO_W      = MAG_W / 2;
    localparam int HI_W      = MAG_W - LO_W;
    localparam int RCP_W     = SAMPLE_W + 2;
    localparam int SUM_W     = MAG_W + RCP_W;
    localparam int DIV_BITS  = $clog2(int'(DIV_MAG) + 1);
    localparam int RCP_SHIFT = SAMPLE_W + DIV_BITS;
    localparam logic [RCP_W-1:0] RECIP = (DIV_MAG == '0) ? '0 :
        RCP_W'((64'd1 << RCP_SHIFT) / 64'(DIV_MAG));

    // History memories; input entries beyond the fill count and output entries at or beyond it count as zero.
    logic signed [SAMPLE_W-1:0] in_mem  [TAPS];
    logic signed [SAMPLE_W-1:0] out_mem [TAPS];

    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] tap_reg, tap_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          full;

    logic                       p1_vld_reg, p2_vld_reg;
    logic                       vin_reg, vout_reg;
    logic signed [SAMPLE_W-1:0] in_rd_reg, out_rd_reg;
    logic signed [COEF_W-1:0]   ff_c_reg, fb_c_reg;
    logic signed [PROD_W-1:0]   prod_ff_reg, prod_fb_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    logic                  neg_reg, ovf_reg, zdiv_reg;
    logic [MAG_W-1:0]      mag_reg;
    logic [LO_W+RCP_W-1:0] prod_lo_reg;
    logic [HI_W+RCP_W-1:0] prod_hi_reg;
    logic [SAMPLE_W-1:0]   qest_reg;
    logic [MAG_W-1:0]      back_reg;
    logic [SAMPLE_W-1:0]   quot_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;

    logic                  vin, vout;
    logic [ACC_W-1:0]      acc_mag;
    logic [SAMPLE_W-1:0]   acc_hi;
    logic [SUM_W-1:0]      recip_sum;
    logic [MAG_W-1:0]      rem_mag;
    logic                  rem_ge;
    logic signed [SAMPLE_W-1:0] result;

    assign full = (fill_reg == FULL_CNT);
    // Ring slot at the current position holds the new input but not yet an output.
    assign vin  = full || (FW'(rd_ptr_reg) <= fill_reg);
    assign vout = full || (FW'(rd_ptr_reg) < fill_reg);

    assign stat.last_tap  = (tap_reg == LAST_IDX);
    assign stat.pipe_busy = p1_vld_reg || p2_vld_reg;

    always_comb begin
        pos_next    = pos_reg;
        rd_ptr_next = rd_ptr_reg;
        tap_next    = tap_reg;
        fill_next   = fill_reg;
        if (cmd.load) begin
            rd_ptr_next = pos_reg;
            tap_next    = '0;
        end else if (cmd.issue) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            tap_next    = tap_reg + 1'b1;
        end
        if (cmd.finish) begin
            pos_next  = (pos_reg == LAST_IDX) ? '0 : pos_reg + 1'b1;
            fill_next = full ? fill_reg : fill_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            rd_ptr_reg <= '0;
            tap_reg    <= '0;
            fill_reg   <= '0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            rd_ptr_reg <= rd_ptr_next;
            tap_reg    <= tap_next;
            fill_reg   <= fill_next;
            p1_vld_reg <= cmd.issue;
            p2_vld_reg <= p1_vld_reg;
        end
    end

    // Memory ports: one write, one registered read each.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_mem[pos_reg] <= sample_in;
        end
        if (cmd.finish) begin
            out_mem[pos_reg] <= result;
        end
        in_rd_reg  <= in_mem[rd_ptr_reg];
        out_rd_reg <= out_mem[rd_ptr_reg];
    end

    // Tap pipeline: lookup, multiply, accumulate. Drop products of unwritten
    // entries, and the tap 0 feedback product, after the read so they never reach the accumulator.
    always_ff @(posedge aclk) begin
        vin_reg  <= vin;
        vout_reg <= vout && (tap_reg != '0);
        ff_c_reg <= ff_coef(COEF_IDX_W'(tap_reg));
        fb_c_reg <= fb_coef(COEF_IDX_W'(tap_reg));
        if (vin_reg) begin
            prod_ff_reg <= ff_c_reg * in_rd_reg;
        end else begin
            prod_ff_reg <= '0;
        end
        if (vout_reg) begin
            prod_fb_reg <= fb_c_reg * out_rd_reg;
        end else begin
            prod_fb_reg <= '0;
        end
        if (cmd.load) begin
            acc_reg <= '0;
        end else if (p2_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_ff_reg) - ACC_W'(prod_fb_reg);
        end
    end

    // Divider: magnitude times reciprocal, then one correction step.
    always_comb begin
        acc_mag   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        acc_hi    = acc_mag[ACC_W-1:ACC_W-SAMPLE_W];
        recip_sum = {prod_hi_reg, {LO_W{1'b0}}} + SUM_W'(prod_lo_reg);
        rem_mag   = mag_reg - back_reg;
        rem_ge    = (rem_mag >= MAG_W'(DIV_MAG));
    end

    // Every stage advances on each step; the quotient settles after DIV_STEPS.
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            neg_reg  <= acc_reg[ACC_W-1] ^ DIVISOR[COEF_W-1];
            zdiv_reg <= (DIV_MAG == '0);
            ovf_reg  <= (acc_hi >= SAMPLE_W'(DIV_MAG));
            mag_reg  <= acc_mag[MAG_W-1:0];
        end else if (cmd.div_step) begin
            prod_lo_reg <= mag_reg[LO_W-1:0] * RECIP;
            prod_hi_reg <= mag_reg[MAG_W-1:LO_W] * RECIP;
            qest_reg    <= recip_sum[RCP_SHIFT +: SAMPLE_W];
            back_reg    <= qest_reg * DIV_MAG;
            quot_reg    <= rem_ge ? qest_reg + 1'b1 : qest_reg;
        end
    end

    // Sign and saturate; zero when the divisor is zero.
    always_comb begin
        if (zdiv_reg) begin
            result = '0;
        end else if (neg_reg) begin
            if (ovf_reg || (quot_reg > {1'b1, {(SAMPLE_W-1){1'b0}}})) begin
                result = SAT_MIN;
            end else begin
                result = SAMPLE_W'(-quot_reg);
            end
        end else begin
            if (ovf_reg || quot_reg[SAMPLE_W-1]) begin
                result = SAT_MAX;
            end else begin
                result = quot_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            sample_out_reg <= result;
        end
    end

    assign sample_out = sample_out_reg;

endmodule

[design/iirdec_ctrl.sv]
`include "assert_macros.svh"

module iirdec_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output iirdec_pkg::idc_cmd_t  cmd,
    input  iirdec_pkg::idc_stat_t stat
);
    import iirdec_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam int DCW = $clog2(DIV_STEPS);
    localparam logic [DCW-1:0] DIV_LAST = DCW'(DIV_STEPS - 1);

    logic [2:0]     state_reg, state_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;
    logic           m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        div_cnt_next  = div_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MAC;
                end
            end
            S_MAC: begin
                cmd.issue = 1'b1;
                if (stat.last_tap) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!stat.pipe_busy) begin
                    cmd.div_init = 1'b1;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.finish    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            div_cnt_reg  <= div_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    `ASSERT_IMPLIES(a_load_pipe_idle, aclk, aresetn, cmd.load, !stat.pipe_busy, "load while tap pipeline busy")
    `ASSERT_IMPLIES(a_finish_slot_free, aclk, aresetn, cmd.finish, !m_tvalid_reg || m_tready, "result overwrites untaken transfer")
    `ASSERT_IMPLIES(a_pipe_in_mac, aclk, aresetn, stat.pipe_busy, (state_reg == S_MAC) || (state_reg == S_DRAIN), "tap pipeline active outside accumulation")
    `ASSERT_NEXT(a_finish_valid, aclk, aresetn, cmd.finish, m_tvalid_reg && (state_reg == S_IDLE), "finished result not presented")

endmodule

[design/iir_difference_equation_controller_top.sv]
// Direct-form-1 IIR filter on signed 32-bit samples. Each input transfer is
// written into a circular input history of TAPS entries; one multiply-accumulate
// pass then walks both the input and output histories from the newest sample,
// one tap per cycle through the single read port of each history memory, adding
// feedforward products and subtracting feedback products (taps 1 and up) into a
// 64-bit accumulator. The sum is divided by feedback coefficient 0 (truncating
// toward zero) by multiplying its magnitude with a fixed reciprocal and
// correcting the estimate by one compare and subtract, saturated to signed
// 32 bits, stored as the newest output and presented on the result channel.
// After acceptance an item passes through TAPS tap reads, a drain of the
// lookup/multiply/accumulate pipeline with the divide set-up, 4 divide stages
// and the result store, after which the result transfer is offered; the store
// waits while an earlier result is still untaken. The next sample is accepted
// the cycle after the store, even while that result waits to be taken. The
// coefficients are fixed tables; history entries never written since reset
// read as zero.
module iir_difference_equation_controller_top #(
    parameter int TAPS = iirdec_pkg::TAPS_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input channel
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic signed [iirdec_pkg::SAMPLE_W-1:0] s_tdata,   // [31:0] sample_in
    // Result channel
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic signed [iirdec_pkg::SAMPLE_W-1:0] m_tdata    // [31:0] sample_out
);
    import iirdec_pkg::*;

    idc_cmd_t  cmd;
    idc_stat_t stat;

    // Sequencer: accept, tap walk, drain, divide, hand off the result transfer.
    iirdec_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Histories, coefficient tables, MAC pipeline, divider and output register.
    iirdec_dp #(
        .TAPS (TAPS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .sample_in  (s_tdata),
        .sample_out (m_tdata)
    );

endmodule
